// ----- hdl/fitsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitsp_pkg
// Shared types and constants of the integer pixel to single converter.
// ----------------------------------------------------------------------------
package fitsp_pkg;

    localparam int COUNT_WIDTH_DEF = 29;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int PIXEL_COUNT_W = 29;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT = 2'd3;

    // sample width modes, anything else is 32-bit signed
    localparam logic [1:0] MODE_U8    = 2'd0;
    localparam logic [1:0] MODE_S16   = 2'd1;
    localparam logic [1:0] MODE_S32   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [1:0]  MODE_RESET  = MODE_S16;
    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } fitsp_in_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        last_pixel;
    } fitsp_out_t;

    // one assembled sample in sign and magnitude form
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic        last;
    } fitsp_sample_t;

endpackage

// ----- hdl/fits_integer_pixel_to_float.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fits_integer_pixel_to_float
// Big-endian 8/16/32-bit image samples to IEEE single, sample*scale+offset.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  bytes     push / full          byte_item   (data_byte, frame_start)
//  pixels    pop / empty          pixel_item  (pixel_value, last_pixel)
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one byte per cycle while the queue is not full; a pixel appears once its last
//  byte has passed the sample queue, eleven pipe stages and the output register
//  the sample queue holds QUEUE_DEPTH samples; the pipe and output register
//  stall together while a result waits, bytes are taken until the queue fills
//  reset leaves the block idle with mode 16-bit, scale 1.0, offset 0.0
//  configuration is taken every cycle
// ----------------------------------------------------------------------------
module fits_integer_pixel_to_float #(
    parameter int COUNT_WIDTH = fitsp_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = fitsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  fitsp_pkg::fitsp_in_t               byte_item,
    output logic                               empty,
    input  logic                               pop,
    output fitsp_pkg::fitsp_out_t              pixel_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fitsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fitsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fitsp_pkg::*;

    logic [1:0]               mode_reg;
    logic [31:0]              scale_reg;
    logic [31:0]              offset_reg;
    logic [PIXEL_COUNT_W-1:0] count_reg;

    logic                     q_full, q_not_empty, q_take, emit;
    fitsp_sample_t            front_sample, q_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            scale_reg  <= SCALE_RESET;
            offset_reg <= '0;
            count_reg  <= PIXEL_COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:        mode_reg   <= cfg_data[1:0];
                REG_SCALE:       scale_reg  <= cfg_data;
                REG_OFFSET:      offset_reg <= cfg_data;
                REG_PIXEL_COUNT: count_reg  <= cfg_data[PIXEL_COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    fitsp_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_item   (byte_item),
        .mode        (mode_reg),
        .pixel_count (count_reg),
        .queue_full  (q_full),
        .emit        (emit),
        .sample      (front_sample)
    );

    fitsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (emit),
        .wr_item   (front_sample),
        .full      (q_full),
        .rd        (q_take),
        .rd_item   (q_sample),
        .not_empty (q_not_empty)
    );

    fitsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_not_empty),
        .in_item    (q_sample),
        .in_take    (q_take),
        .scale      (scale_reg),
        .offset     (offset_reg),
        .empty      (empty),
        .pop        (pop),
        .pixel_item (pixel_item)
    );

endmodule

// ----- hdl/fitsp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitsp_front
// Byte assembly, frame and pixel counting, sample sign extraction.
// ----------------------------------------------------------------------------
module fitsp_front #(
    parameter int COUNT_WIDTH = fitsp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  fitsp_pkg::fitsp_in_t                   byte_item,
    input  logic [1:0]                             mode,
    input  logic [fitsp_pkg::PIXEL_COUNT_W-1:0]    pixel_count,
    input  logic                                   queue_full,
    output logic                                   emit,
    output fitsp_pkg::fitsp_sample_t               sample
);
    import fitsp_pkg::*;

    logic [1:0]             phase_reg, phase_next;
    logic [23:0]            partial_reg, partial_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;

    logic                   accept;
    logic [1:0]             phase_v;
    logic [23:0]            partial_v;
    logic [COUNT_WIDTH-1:0] left_v;
    logic [2:0]             need;
    logic [31:0]            acc;
    logic [31:0]            sext;

    assign full   = queue_full;
    assign accept = push && !queue_full;
    assign acc    = {partial_v, byte_item.data_byte};

    always_comb
    begin
        phase_v   = phase_reg;
        partial_v = partial_reg;
        left_v    = left_reg;
        if (accept && byte_item.frame_start)
        begin
            phase_v   = '0;
            partial_v = '0;
            left_v    = COUNT_WIDTH'(pixel_count);
        end
    end

    always_comb
    begin
        case (mode)
            MODE_U8:  need = 3'd1;
            MODE_S16: need = 3'd2;
            default:  need = 3'd4;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_v;
        partial_next = partial_v;
        left_next    = left_v;
        emit         = 1'b0;
        if (accept && left_v != '0)
        begin
            if ({1'b0, phase_v} + 3'd1 < need)
            begin
                partial_next = acc[23:0];
                phase_next   = phase_v + 2'd1;
            end
            else
            begin
                phase_next   = '0;
                partial_next = '0;
                left_next    = left_v - COUNT_WIDTH'(1);
                emit         = 1'b1;
            end
        end
    end

    always_comb
    begin
        sext = acc;
        case (mode)
            MODE_U8:
            begin
                sample.neg = 1'b0;
                sample.mag = {24'b0, acc[7:0]};
            end
            MODE_S16:
            begin
                sext       = {{16{acc[15]}}, acc[15:0]};
                sample.neg = acc[15];
                sample.mag = acc[15] ? 32'd0 - sext : sext;
            end
            default:
            begin
                sample.neg = acc[31];
                sample.mag = acc[31] ? 32'd0 - acc : acc;
            end
        endcase
        sample.last = (left_v == COUNT_WIDTH'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            partial_reg <= '0;
            left_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            left_reg    <= left_next;
        end
    end

endmodule

// ----- hdl/fitsp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitsp_queue
// Short sample queue between the byte front end and the arithmetic pipe.
// ----------------------------------------------------------------------------
module fitsp_queue #(
    parameter int DEPTH = fitsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr,
    input  fitsp_pkg::fitsp_sample_t  wr_item,
    output logic                      full,
    input  logic                      rd,
    output fitsp_pkg::fitsp_sample_t  rd_item,
    output logic                      not_empty
);
    import fitsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fitsp_sample_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;
    assign rd_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/fitsp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitsp_back
// Pipelined sample * scale + offset, double rounding then single rounding.
// ----------------------------------------------------------------------------
module fitsp_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  fitsp_pkg::fitsp_sample_t in_item,
    output logic                     in_take,
    input  logic [31:0]              scale,
    input  logic [31:0]              offset,
    output logic                     empty,
    input  logic                     pop,
    output fitsp_pkg::fitsp_out_t    pixel_item
);
    import fitsp_pkg::*;

    localparam int EW = 11;

    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_NAN,
        SPEC_POS_INF,
        SPEC_NEG_INF
    } spec_t;

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       hit;
        n   = 7'd64;
        hit = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!hit && v[i])
            begin
                n   = 7'(63 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    logic adv;

    // ---------------- stage 1: multiply ----------------
    logic          s_ef_zero;
    logic [7:0]    s_ef_eff;
    logic [23:0]   s_sig;
    logic          scale_nan, scale_inf, off_nan, off_inf;
    logic          prod_nan, prod_inf, p_sign;
    spec_t         spec1_next;

    logic          v1_reg;
    logic          last1_reg, sign1_reg;
    spec_t         spec1_reg;
    logic [EW-1:0] e1_reg;
    logic [54:0]   p1_reg;

    assign s_ef_zero = (scale[30:23] == 8'd0);
    assign s_ef_eff  = s_ef_zero ? 8'd1 : scale[30:23];
    assign s_sig     = {!s_ef_zero, scale[22:0]};
    assign scale_nan = (scale[30:23] == 8'hFF) && (scale[22:0] != '0);
    assign scale_inf = (scale[30:23] == 8'hFF) && (scale[22:0] == '0);
    assign off_nan   = (offset[30:23] == 8'hFF) && (offset[22:0] != '0);
    assign off_inf   = (offset[30:23] == 8'hFF) && (offset[22:0] == '0);
    assign p_sign    = in_item.neg ^ scale[31];
    assign prod_nan  = scale_nan || (scale_inf && in_item.mag == '0);
    assign prod_inf  = scale_inf && in_item.mag != '0;

    always_comb
    begin
        if (prod_nan || off_nan)
            spec1_next = SPEC_NAN;
        else if (prod_inf && off_inf && p_sign != offset[31])
            spec1_next = SPEC_NAN;
        else if (prod_inf)
            spec1_next = p_sign ? SPEC_NEG_INF : SPEC_POS_INF;
        else if (off_inf)
            spec1_next = offset[31] ? SPEC_NEG_INF : SPEC_POS_INF;
        else
            spec1_next = SPEC_NONE;
    end

    // ---------------- stage 2: round product to 53 bits ----------------
    logic [52:0]   keep2;
    logic          g2, st2, up2;
    logic [1:0]    sh2;

    logic          v2_reg, last2_reg, sign2_reg;
    spec_t         spec2_reg;
    logic [EW-1:0] e2_reg;
    logic [53:0]   q2_reg;

    always_comb
    begin
        if (p1_reg[54])
        begin
            keep2 = p1_reg[54:2];
            g2    = p1_reg[1];
            st2   = p1_reg[0];
            sh2   = 2'd2;
        end
        else if (p1_reg[53])
        begin
            keep2 = p1_reg[53:1];
            g2    = p1_reg[0];
            st2   = 1'b0;
            sh2   = 2'd1;
        end
        else
        begin
            keep2 = p1_reg[52:0];
            g2    = 1'b0;
            st2   = 1'b0;
            sh2   = 2'd0;
        end
        up2 = g2 && (st2 || keep2[0]);
    end

    // ---------------- stage 3: product leading zeros ----------------
    logic          v3_reg, last3_reg, sign3_reg;
    spec_t         spec3_reg;
    logic [EW-1:0] e3_reg;
    logic [53:0]   q3_reg;
    logic [5:0]    lz3_reg;

    // ---------------- stage 4: normalize product and offset ----------------
    logic          o_ef_zero;
    logic [7:0]    o_ef_eff;
    logic [23:0]   o_sig;
    logic [4:0]    o_lz;
    logic [52:0]   px4_next, ox4_next;
    logic [EW-1:0] pe4_next, oe4_next;

    logic          v4_reg, last4_reg, ps4_reg, os4_reg, pz4_reg, oz4_reg;
    spec_t         spec4_reg;
    logic [52:0]   px4_reg, ox4_reg;
    logic [EW-1:0] pe4_reg, oe4_reg;

    assign o_ef_zero = (offset[30:23] == 8'd0);
    assign o_ef_eff  = o_ef_zero ? 8'd1 : offset[30:23];
    assign o_sig     = {!o_ef_zero, offset[22:0]};
    assign o_lz      = 5'(lzc64({o_sig, 40'hFF_FFFF_FFFF}));
    assign ox4_next  = {o_sig, 29'b0} << o_lz;
    assign oe4_next  = $signed({3'b0, o_ef_eff}) - EW'(150) - EW'(29)
                       - $signed({6'b0, o_lz});

    always_comb
    begin
        if (q3_reg[53])
        begin
            px4_next = q3_reg[53:1];
            pe4_next = e3_reg + EW'(1);
        end
        else
        begin
            px4_next = q3_reg[52:0] << lz3_reg;
            pe4_next = e3_reg - $signed({5'b0, lz3_reg});
        end
    end

    // ---------------- stage 5: order operands ----------------
    logic          p_big;
    logic [EW-1:0] d5;

    logic          v5_reg, last5_reg, xs5_reg, sub5_reg, bz5_reg, zs5_reg;
    spec_t         spec5_reg;
    logic [52:0]   xm5_reg, ym5_reg;
    logic [EW-1:0] xe5_reg;
    logic [5:0]    dd5_reg;

    assign p_big = oz4_reg || (!pz4_reg && ($signed(pe4_reg) > $signed(oe4_reg)
                   || (pe4_reg == oe4_reg && px4_reg >= ox4_reg)));
    assign d5    = p_big ? pe4_reg - oe4_reg : oe4_reg - pe4_reg;

    // ---------------- stage 6: align smaller operand ----------------
    logic [109:0]  wide6;

    logic          v6_reg, last6_reg, xs6_reg, sub6_reg, bz6_reg, zs6_reg;
    spec_t         spec6_reg;
    logic [55:0]   x6_reg, a6_reg;
    logic [EW-1:0] e6_reg;

    assign wide6 = {ym5_reg, 57'b0} >> dd5_reg;

    // ---------------- stage 7: add or subtract ----------------
    logic [56:0]   sum7_next;

    logic          v7_reg, last7_reg, s7_reg, z7_reg;
    spec_t         spec7_reg;
    logic [56:0]   sum7_reg;
    logic [EW-1:0] e7_reg;

    assign sum7_next = sub6_reg ? {1'b0, x6_reg} - {1'b0, a6_reg}
                                : {1'b0, x6_reg} + {1'b0, a6_reg};

    // ---------------- stage 8: sum leading zeros ----------------
    logic          v8_reg, last8_reg, s8_reg, z8_reg;
    spec_t         spec8_reg;
    logic [56:0]   sum8_reg;
    logic [EW-1:0] e8_reg;
    logic [5:0]    lz8_reg;

    // ---------------- stage 9: normalize sum ----------------
    logic          v9_reg, last9_reg, s9_reg, z9_reg;
    spec_t         spec9_reg;
    logic [55:0]   n9_reg;
    logic [EW-1:0] e9_reg;

    // ---------------- stage 10: round to double ----------------
    logic [53:0]   m10;
    logic          up10;

    logic          v10_reg, last10_reg, s10_reg, z10_reg;
    spec_t         spec10_reg;
    logic [52:0]   dm10_reg;
    logic [EW-1:0] de10_reg;

    assign up10 = n9_reg[2] && (n9_reg[1] || n9_reg[0] || n9_reg[3]);
    assign m10  = {1'b0, n9_reg[55:3]} + 54'(up10);

    // ---------------- stage 11: single alignment ----------------
    logic [EW-1:0]  t11;
    logic [5:0]     drop11;
    logic [8:0]     base11;
    logic [108:0]   wide11;

    logic          v11_reg, last11_reg, s11_reg, z11_reg, g11_reg, st11_reg;
    spec_t         spec11_reg;
    logic [23:0]   k11_reg;
    logic [8:0]    base11_reg;

    assign t11 = -EW'(149) - de10_reg;

    always_comb
    begin
        // normal single range keeps 24 bits, below it the lsb is pinned at 2^-149
        if ($signed(de10_reg) >= -$signed(EW'(178)))
        begin
            drop11 = 6'd29;
            base11 = 9'(de10_reg + EW'(178));
        end
        else
        begin
            drop11 = ($signed(t11) > $signed(EW'(55))) ? 6'd55 : t11[5:0];
            base11 = '0;
        end
    end

    assign wide11 = {dm10_reg, 56'b0} >> drop11;

    // ---------------- stage 12: round and pack ----------------
    logic [24:0]   r12;
    logic [31:0]   mag12;
    logic [31:0]   bits12;

    logic          out_valid_reg;
    fitsp_out_t    out_item_reg;

    assign r12   = {1'b0, k11_reg} + 25'(g11_reg && (st11_reg || k11_reg[0]));
    assign mag12 = {base11_reg, 23'b0} + 32'(r12);

    always_comb
    begin
        case (spec11_reg)
            SPEC_NAN:     bits12 = 32'h7FC0_0000;
            SPEC_POS_INF: bits12 = 32'h7F80_0000;
            SPEC_NEG_INF: bits12 = 32'hFF80_0000;
            default:
            begin
                if (z11_reg)
                    bits12 = {s11_reg, 31'b0};
                else if (mag12 >= 32'h7F80_0000)
                    bits12 = {s11_reg, 31'h7F80_0000};
                else
                    bits12 = {s11_reg, mag12[30:0]};
            end
        endcase
    end

    assign adv        = !out_valid_reg || pop;
    assign in_take    = adv && in_valid;
    assign empty      = !out_valid_reg;
    assign pixel_item = out_item_reg;

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last1_reg  <= in_item.last;
            sign1_reg  <= p_sign;
            spec1_reg  <= spec1_next;
            e1_reg     <= $signed({3'b0, s_ef_eff}) - EW'(150);
            p1_reg     <= 55'(in_item.mag) * 55'(s_sig);

            last2_reg  <= last1_reg;
            sign2_reg  <= sign1_reg;
            spec2_reg  <= spec1_reg;
            e2_reg     <= e1_reg + $signed({9'b0, sh2});
            q2_reg     <= {1'b0, keep2} + 54'(up2);

            last3_reg  <= last2_reg;
            sign3_reg  <= sign2_reg;
            spec3_reg  <= spec2_reg;
            e3_reg     <= e2_reg;
            q3_reg     <= q2_reg;
            lz3_reg    <= 6'(lzc64({q2_reg[52:0], 11'h7FF}));

            last4_reg  <= last3_reg;
            spec4_reg  <= spec3_reg;
            ps4_reg    <= sign3_reg;
            pz4_reg    <= (q3_reg == '0);
            px4_reg    <= px4_next;
            pe4_reg    <= pe4_next;
            os4_reg    <= offset[31];
            oz4_reg    <= (o_sig == '0);
            ox4_reg    <= ox4_next;
            oe4_reg    <= oe4_next;

            last5_reg  <= last4_reg;
            spec5_reg  <= spec4_reg;
            xs5_reg    <= p_big ? ps4_reg : os4_reg;
            xm5_reg    <= p_big ? px4_reg : ox4_reg;
            xe5_reg    <= p_big ? pe4_reg : oe4_reg;
            ym5_reg    <= p_big ? ox4_reg : px4_reg;
            dd5_reg    <= ($signed(d5) > $signed(EW'(57))) ? 6'd57 : d5[5:0];
            sub5_reg   <= ps4_reg ^ os4_reg;
            bz5_reg    <= pz4_reg && oz4_reg;
            zs5_reg    <= ps4_reg && os4_reg;

            last6_reg  <= last5_reg;
            spec6_reg  <= spec5_reg;
            xs6_reg    <= xs5_reg;
            sub6_reg   <= sub5_reg;
            bz6_reg    <= bz5_reg;
            zs6_reg    <= zs5_reg;
            x6_reg     <= {xm5_reg, 3'b0};
            // guard, round, then sticky folded into the lsb
            a6_reg     <= {wide6[109:55], |wide6[54:0]};
            e6_reg     <= xe5_reg - EW'(3);

            last7_reg  <= last6_reg;
            spec7_reg  <= spec6_reg;
            sum7_reg   <= sum7_next;
            e7_reg     <= e6_reg;
            z7_reg     <= (sum7_next == '0);
            s7_reg     <= (sum7_next == '0) ? (bz6_reg && zs6_reg) : xs6_reg;

            last8_reg  <= last7_reg;
            spec8_reg  <= spec7_reg;
            s8_reg     <= s7_reg;
            z8_reg     <= z7_reg;
            sum8_reg   <= sum7_reg;
            e8_reg     <= e7_reg;
            lz8_reg    <= 6'(lzc64({sum7_reg[55:0], 8'hFF}));

            last9_reg  <= last8_reg;
            spec9_reg  <= spec8_reg;
            s9_reg     <= s8_reg;
            z9_reg     <= z8_reg;
            if (sum8_reg[56])
            begin
                n9_reg <= {sum8_reg[56:2], sum8_reg[1] | sum8_reg[0]};
                e9_reg <= e8_reg + EW'(1);
            end
            else
            begin
                n9_reg <= sum8_reg[55:0] << lz8_reg;
                e9_reg <= e8_reg - $signed({5'b0, lz8_reg});
            end

            last10_reg <= last9_reg;
            spec10_reg <= spec9_reg;
            s10_reg    <= s9_reg;
            z10_reg    <= z9_reg;
            if (m10[53])
            begin
                dm10_reg <= m10[53:1];
                de10_reg <= e9_reg + EW'(4);
            end
            else
            begin
                dm10_reg <= m10[52:0];
                de10_reg <= e9_reg + EW'(3);
            end

            last11_reg <= last10_reg;
            spec11_reg <= spec10_reg;
            s11_reg    <= s10_reg;
            z11_reg    <= z10_reg;
            k11_reg    <= wide11[79:56];
            g11_reg    <= wide11[55];
            st11_reg   <= |wide11[54:0];
            base11_reg <= base11;

            out_item_reg.pixel_value <= bits12;
            out_item_reg.last_pixel  <= last11_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            out_valid_reg <= v11_reg;
        end
    end

endmodule

// ----- verif/fits_integer_pixel_to_float_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fits_integer_pixel_to_float_tb
// Checks the byte stream to IEEE single pixel converter against its own
// predictor: big-endian sample assembly in all widths, scale and offset in
// double precision, rounding to single, frame and idle handling, under
// random idling, long output stalls and register changes between phases.
// ----------------------------------------------------------------------------
module fits_integer_pixel_to_float_tb;
    import fitsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_PHASES  = 24;
    localparam int BEATS_PER_PHASE = 62;

    class pixel_scoreboard;
        logic [1:0]  mode;
        logic [31:0] scale;
        logic [31:0] offset;
        logic [28:0] count;
        logic [1:0]  phase;
        logic [23:0] partial;
        logic [28:0] left;
        fitsp_out_t  expected_q[$];
        int          errors;
        int          pixels;
        int          bytes_in;

        function new();
            mode    = MODE_RESET;
            scale   = SCALE_RESET;
            offset  = 32'h0;
            count   = 29'd1;
            phase   = 2'd0;
            partial = 24'h0;
            left    = 29'd0;
            errors  = 0;
            pixels  = 0;
            bytes_in = 0;
        endfunction

        // exact widening of an IEEE single, denormals included
        function real single_to_real(logic [31:0] b);
            logic [63:0] d;
            logic [22:0] m;
            int          p;
            m = b[22:0];
            d = 64'h0;
            if (b[30:23] == 8'hFF)
                d = {b[31], 11'h7FF, m, 29'b0};
            else if (b[30:23] == 8'h00)
            begin
                d = {b[31], 63'b0};
                if (m != 23'h0)
                begin
                    p = 22;
                    while (!m[p])
                        p--;
                    d[62:52] = 11'(p - 149 + 1023);
                    d[51:0]  = 52'(m) << (52 - p);
                end
            end
            else
                d = {b[31], {3'b0, b[30:23]} + 11'd896, m, 29'b0};
            return $bitstoreal(d);
        endfunction

        // round to nearest even single, nan made quiet
        function logic [31:0] real_to_single(real x);
            logic [63:0] d;
            logic [63:0] sig;
            logic [63:0] rem;
            logic [63:0] half;
            logic [63:0] q;
            logic [31:0] r;
            int          e;
            int          sh;
            d = $realtobits(x);
            if (d[62:52] == 11'h7FF)
                return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 31'h7F80_0000};
            if (d[62:52] == 11'h0)
                return {d[63], 31'b0};
            e = int'(d[62:52]) - 1023;
            if (e > 127)
                return {d[63], 31'h7F80_0000};
            sig = {11'b0, 1'b1, d[51:0]};
            sh  = (e >= -126) ? 29 : 29 + (-126 - e);
            if (sh >= 55)
                return {d[63], 31'b0};
            q    = sig >> sh;
            rem  = sig & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
            // leading one of q bumps the exponent field by one
            if (e >= -126)
                r = 32'((e + 126) << 23) + q[31:0];
            else
                r = q[31:0];
            return {d[63], r[30:0]};
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:        mode   = data[1:0];
                REG_SCALE:       scale  = data;
                REG_OFFSET:      offset = data;
                REG_PIXEL_COUNT: count  = data[28:0];
                default: ;
            endcase
        endfunction

        function void note_byte(fitsp_in_t it);
            int          nb;
            logic [31:0] acc;
            longint      s;
            real         prod;
            real         sum;
            fitsp_out_t  px;
            bytes_in++;
            if (it.frame_start)
            begin
                phase   = 2'd0;
                partial = 24'h0;
                left    = count;
            end
            if (left == 29'd0)
                return;
            nb  = (mode == MODE_U8) ? 1 : (mode == MODE_S16) ? 2 : 4;
            acc = {partial, it.data_byte};
            if (int'(phase) + 1 < nb)
            begin
                partial = acc[23:0];
                phase   = phase + 2'd1;
                return;
            end
            phase   = 2'd0;
            partial = 24'h0;
            if (nb == 1)
                s = longint'(acc[7:0]);
            else if (nb == 2)
                s = longint'($signed(acc[15:0]));
            else
                s = longint'($signed(acc));
            prod = real'(s) * single_to_real(scale);
            sum  = prod + single_to_real(offset);
            left = left - 29'd1;
            px.pixel_value = real_to_single(sum);
            px.last_pixel  = (left == 29'd0);
            expected_q.push_back(px);
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
        endfunction

        function void check_pixel(fitsp_out_t got);
            fitsp_out_t exp_px;
            if (expected_q.size() == 0)
            begin
                report("unexpected pixel", 32'h0, got.pixel_value);
                return;
            end
            exp_px = expected_q.pop_front();
            pixels++;
            if (got.pixel_value !== exp_px.pixel_value)
                report("pixel_value", exp_px.pixel_value, got.pixel_value);
            if (got.last_pixel !== exp_px.last_pixel)
                report("last_pixel", 32'(exp_px.last_pixel), 32'(got.last_pixel));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    fitsp_in_t              byte_item;
    logic                   empty;
    logic                   pop;
    fitsp_out_t             pixel_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pixel_scoreboard sb;
    int send_idle;
    int recv_stall;
    int hold_cycles;
    int quiet_cycles;
    int phases_run;

    fits_integer_pixel_to_float dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .byte_item (byte_item),
        .empty     (empty),
        .pop       (pop),
        .pixel_item(pixel_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // monitor: every accepted beat goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (push && !full)
                sb.note_byte(byte_item);
            if (pop && !empty)
                sb.check_pixel(pixel_item);
            if ((cfg_valid && cfg_ready) || (push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_cycles > 0)
        begin
            pop <= 1'b0;
            hold_cycles--;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_byte(input logic [7:0] d, input logic fs);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        byte_item <= '{data_byte: d, frame_start: fs};
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait for all pixels, then let bytes still in the pipe settle
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] m, input logic [31:0] s,
                             input logic [31:0] o, input logic [28:0] n);
        write_reg(REG_MODE, {30'b0, m});
        write_reg(REG_SCALE, s);
        write_reg(REG_OFFSET, o);
        write_reg(REG_PIXEL_COUNT, {3'b0, n});
        phases_run++;
    endtask

    function automatic logic [31:0] pick_float();
        case ($urandom_range(9))
            0: return 32'h3F80_0000;
            1: return 32'h0000_0000;
            2: return 32'h8000_0000;
            3: return 32'h7F7F_FFFF;
            4: return 32'h0000_0001;
            5: return ($urandom_range(1) != 0) ? 32'h7F80_0000 : 32'hFF80_0000;
            6: return {1'($urandom_range(1)), 8'($urandom_range(120, 134)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [28:0] pick_count();
        case ($urandom_range(19))
            0: return 29'd0;
            1: return 29'h1FFF_FFFF;
            2: return 29'h1000_0000;
            default: return 29'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic run_random_phase(input int idx);
        logic [1:0]  m;
        logic [28:0] n;
        longint      until_next;
        logic        fs;
        int          nb;
        case (idx % 4)
            0:
            begin
                send_idle = 0;  recv_stall = 0;
            end
            1:
            begin
                send_idle = 47; recv_stall = 0;
            end
            2:
            begin
                send_idle = 0;  recv_stall = 47;
            end
            default:
            begin
                send_idle = 26; recv_stall = 26;
            end
        endcase
        m = 2'($urandom_range(3));
        n = pick_count();
        // the long hold-off needs a steady pixel stream to fill the block
        if (idx == 5)
        begin
            m = MODE_U8;
            n = 29'd40;
        end
        configure(m, pick_float(), pick_float(), n);
        nb = (m == MODE_U8) ? 1 : (m == MODE_S16) ? 2 : 4;
        // fill the block while the receiver is held off
        if (idx == 5)
            hold_cycles = 400;
        until_next = ($urandom_range(9) != 0) ? 0 : 3;
        for (int i = 0; i < BEATS_PER_PHASE; i++)
        begin
            fs = (until_next == 0) || ($urandom_range(99) == 0);
            if (fs)
                until_next = longint'(n) * nb + $urandom_range(2);
            send_byte(8'($urandom), fs);
            if (until_next > 0)
                until_next--;
            if (idx == 10 && i == BEATS_PER_PHASE / 2)
            begin
                push <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        byte_item = '0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        phases_run = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before any frame start are dropped
        send_byte(8'hAA, 1'b0);
        drain();
        // 16-bit extremes
        configure(MODE_S16, 32'h3F80_0000, 32'h0, 29'd5);
        send_byte(8'h7F, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0);
        send_byte(8'h12, 1'b0);
        drain();
        // 8-bit samples are unsigned
        configure(MODE_U8, 32'h4000_0000, 32'hBF80_0000, 29'd3);
        send_byte(8'hFF, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
        drain();
        // 32-bit overflow to infinity
        configure(MODE_S32, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 29'd2);
        send_byte(8'h7F, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        drain();
        // unused mode, zero times infinity gives nan
        configure(MODE_SPARE, 32'h7F80_0000, 32'h0, 29'd2);
        send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        drain();
        // zero pixel count stays idle
        configure(MODE_S16, 32'h3F80_0000, 32'h0, 29'd0);
        send_byte(8'h11, 1'b1); send_byte(8'h22, 1'b0);
        drain();
        // restart mid-sample, then a mode change mid-sample
        configure(MODE_S16, 32'h0000_0001, 32'h0, 29'h1FFF_FFFF);
        send_byte(8'h01, 1'b1); send_byte(8'h02, 1'b1);
        drain();
        configure(MODE_U8, 32'h0000_0001, 32'h8000_0001, 29'd1);
        send_byte(8'h03, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(p);

        $display("%0d bytes in %0d register settings, %0d pixels checked",
                 sb.bytes_in, phases_run, sb.pixels);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches, %0d pixels missing", sb.errors, sb.pending());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
